/* src/sr2s_pkg.sv */
// Shared types, constants and helpers for signed_radix_to_symbols.
// No dependencies; imported by every module of the block.
package sr2s_pkg;

    localparam int ALPHA_WORDS = 5;
    localparam int MAX_SYMBOLS = 40;
    localparam int MAG_W       = 32;
    localparam int DIGIT_W     = 6;
    localparam int MAX_DIGITS  = 32;
    localparam int DIGIT_AW    = 5;
    localparam int DIV_BITS    = 8;
    localparam int DIV_STEPS   = MAG_W / DIV_BITS;
    localparam int DIV_SW      = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int CFG_IDX_W   = 3;

    localparam logic [7:0] SYM_PLUS  = 8'd43;
    localparam logic [7:0] SYM_MINUS = 8'd45;
    localparam logic [7:0] SYM_LOW   = 8'd32;
    localparam logic [7:0] SYM_HIGH  = 8'd126;

    localparam logic [DIGIT_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX = DIGIT_W'(MAX_SYMBOLS);

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 3'd5;

    typedef logic [ALPHA_WORDS-1:0][7:0][7:0] t_alphabet;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_job;

    function automatic logic [7:0] sym_at(t_alphabet a, logic [DIGIT_W-1:0] idx);
        logic [7:0] s;
        s = 8'd0;
        if (idx[5:3] < 3'(ALPHA_WORDS)) begin
            s = a[idx[5:3]][idx[2:0]];
        end
        return s;
    endfunction

endpackage

/* src/sr2s_in_if.sv */
// Input channel: one signed 32-bit number per word.
// Depends on nothing.
interface sr2s_in_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

/* src/sr2s_out_if.sv */
// Output channel: one symbol code per word with a last-of-run flag.
// Depends on nothing.
interface sr2s_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] symbol;
    logic       final_res;

    modport source (output valid, output symbol, output final_res, input ready);
    modport sink   (input valid, input symbol, input final_res, output ready);
endinterface

/* src/sr2s_front.sv */
// Front end: configuration registers, alphabet checker, input classification.
// Depends on sr2s_pkg and sr2s_in_if.
module sr2s_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [sr2s_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [63:0]                       i_cfg_wdata,
    sr2s_in_if.sink                           i_num_ch,
    output logic                              o_push,
    output sr2s_pkg::t_job                    o_job,
    input  logic                              i_full,
    output sr2s_pkg::t_alphabet               o_alpha,
    output logic [sr2s_pkg::DIGIT_W-1:0]      o_radix
);
    import sr2s_pkg::*;

    t_alphabet          r_alpha;
    logic [DIGIT_W-1:0] r_radix;
    logic               r_chk_busy;
    logic               r_alpha_ok;
    logic [DIGIT_W-1:0] r_chk_idx;
    logic [127:0]       r_seen;

    logic [7:0] chk_sym;
    logic       sym_bad;
    logic       len_bad;

    assign chk_sym = sym_at(r_alpha, r_chk_idx);
    assign sym_bad = (chk_sym < SYM_LOW) || (chk_sym > SYM_HIGH) ||
                     (chk_sym == SYM_PLUS) || (chk_sym == SYM_MINUS) ||
                     r_seen[chk_sym[6:0]];
    assign len_bad = (r_radix < RADIX_MIN) || (r_radix > RADIX_MAX);

    // invalid alphabet: words are taken and dropped
    assign i_num_ch.ready = !r_chk_busy && (!r_alpha_ok || !i_full);
    assign o_push         = i_num_ch.valid && i_num_ch.ready && r_alpha_ok;
    assign o_job.neg      = i_num_ch.number[31];
    assign o_job.mag      = i_num_ch.number[31] ? (~i_num_ch.number + 32'd1)
                                                : i_num_ch.number;
    assign o_alpha        = r_alpha;
    assign o_radix        = r_radix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha    <= '0;
            r_radix    <= '0;
            r_chk_busy <= 1'b0;
            r_alpha_ok <= 1'b0;
            r_chk_idx  <= '0;
            r_seen     <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index < CFG_IDX_W'(ALPHA_WORDS)) begin
                r_alpha[i_cfg_index] <= i_cfg_wdata;
            end else if (i_cfg_index == CFG_RADIX) begin
                r_radix <= i_cfg_wdata[DIGIT_W-1:0];
            end
            r_chk_busy <= 1'b1;
            r_alpha_ok <= 1'b0;
            r_chk_idx  <= '0;
            r_seen     <= '0;
        end else if (r_chk_busy) begin
            if (len_bad || sym_bad) begin
                r_chk_busy <= 1'b0;
            end else begin
                r_seen[chk_sym[6:0]] <= 1'b1;
                if (r_chk_idx == r_radix - 6'd1) begin
                    r_chk_busy <= 1'b0;
                    r_alpha_ok <= 1'b1;
                end else begin
                    r_chk_idx <= r_chk_idx + 6'd1;
                end
            end
        end
    end

endmodule

/* src/sr2s_queue.sv */
// Two-entry job queue between front end and back end.
// Depends on sr2s_pkg.
module sr2s_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sr2s_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output sr2s_pkg::t_job o_job,
    input  logic           i_pop
);
    import sr2s_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/sr2s_back.sv */
// Back end: iterative digit extraction, digit stack, symbol output register.
// Depends on sr2s_pkg and sr2s_out_if.
module sr2s_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  sr2s_pkg::t_job               i_job,
    output logic                         o_pop,
    input  sr2s_pkg::t_alphabet          i_alpha,
    input  logic [sr2s_pkg::DIGIT_W-1:0] i_radix,
    sr2s_out_if.source                   o_sym_ch
);
    import sr2s_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SIGN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state             r_state;
    logic [MAG_W-1:0]   r_work;
    logic [DIGIT_W-1:0] r_rem;
    logic [DIV_SW-1:0]  r_step;
    logic               r_neg;
    logic [DIGIT_W-1:0] r_nd;
    logic [DIGIT_W-1:0] r_digits [MAX_DIGITS];
    logic               r_out_valid;
    logic [6:0]         r_out_symbol;
    logic               r_out_final;

    logic [MAG_W-1:0]   n_work;
    logic [DIGIT_W-1:0] n_rem;
    logic               load_ok;
    logic               emit_load;
    logic [DIGIT_W-1:0] top_idx;
    logic [7:0]         emit_sym;

    // restoring division, DIV_BITS quotient bits per cycle
    always_comb begin
        logic [DIGIT_W:0] t;
        n_work = r_work;
        n_rem  = r_rem;
        for (int k = 0; k < DIV_BITS; k++) begin
            t      = {n_rem, n_work[MAG_W-1]};
            n_work = {n_work[MAG_W-2:0], 1'b0};
            if (t >= {1'b0, i_radix}) begin
                n_rem     = DIGIT_W'(t - {1'b0, i_radix});
                n_work[0] = 1'b1;
            end else begin
                n_rem = t[DIGIT_W-1:0];
            end
        end
    end

    assign load_ok   = !r_out_valid || o_sym_ch.ready;
    assign emit_load = load_ok && ((r_state == S_SIGN) || (r_state == S_EMIT));
    assign top_idx   = r_nd - 6'd1;
    assign emit_sym  = sym_at(i_alpha, r_digits[top_idx[DIGIT_AW-1:0]]);
    assign o_pop     = (r_state == S_IDLE) && i_valid;

    assign o_sym_ch.valid     = r_out_valid;
    assign o_sym_ch.symbol    = r_out_symbol;
    assign o_sym_ch.final_res = r_out_final;

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DIV) && (r_step == DIV_SW'(DIV_STEPS - 1))) begin
            r_digits[r_nd[DIGIT_AW-1:0]] <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_work      <= '0;
            r_rem       <= '0;
            r_step      <= '0;
            r_neg       <= 1'b0;
            r_nd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_sym_ch.ready && !emit_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_work  <= i_job.mag;
                        r_neg   <= i_job.neg;
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_nd    <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_work <= n_work;
                    r_rem  <= (r_step == DIV_SW'(DIV_STEPS - 1)) ? '0 : n_rem;
                    r_step <= r_step + 1'b1;
                    if (r_step == DIV_SW'(DIV_STEPS - 1)) begin
                        r_nd <= r_nd + 6'd1;
                        if (n_work == '0) begin
                            r_state <= r_neg ? S_SIGN : S_EMIT;
                        end
                    end
                end
                S_SIGN: begin
                    if (load_ok) begin
                        r_out_valid  <= 1'b1;
                        r_out_symbol <= SYM_MINUS[6:0];
                        r_out_final  <= 1'b0;
                        r_state      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (load_ok) begin
                        r_out_valid  <= 1'b1;
                        r_out_symbol <= emit_sym[6:0];
                        r_out_final  <= (r_nd == 6'd1);
                        r_nd         <= top_idx;
                        if (r_nd == 6'd1) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* src/signed_radix_to_symbols.sv */
// Top level of signed_radix_to_symbols: front end, job queue, back end.
// Depends on sr2s_pkg, sr2s_in_if, sr2s_out_if, sr2s_front, sr2s_queue, sr2s_back.
//
// Usage: write the five alphabet words and radix_length on the cfg port while
// the block is idle. Each write starts an alphabet check of up to 40 symbols
// (one symbol per cycle); i_num_ch.ready stays low until it finishes.
// i_num_ch takes one signed 32-bit word per handshake. With a valid alphabet
// each number yields a run on o_sym_ch: a minus sign if negative, then the
// digits most significant first, final_res set on the last symbol. With an
// invalid alphabet numbers are taken and dropped.
// Timing: digit extraction runs one 8-bit division step per cycle over the
// 32-bit magnitude for each digit, then the symbols leave one per cycle while
// the receiver is ready. A two-word queue lets the next numbers be taken
// while one is converted. o_sym_ch has an output register; when the receiver
// stalls the run holds and, once the queue fills, input ready drops.
// Reset clears the configuration to zero (invalid alphabet) and empties the
// queue and the output register.
module signed_radix_to_symbols (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [sr2s_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_wdata,
    sr2s_in_if.sink                        i_num_ch,
    sr2s_out_if.source                     o_sym_ch
);
    import sr2s_pkg::*;

    logic               push;
    t_job               push_job;
    logic               q_full;
    logic               q_valid;
    t_job               q_job;
    logic               pop;
    t_alphabet          alpha;
    logic [DIGIT_W-1:0] radix;

    sr2s_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_num_ch    (i_num_ch),
        .o_push      (push),
        .o_job       (push_job),
        .i_full      (q_full),
        .o_alpha     (alpha),
        .o_radix     (radix)
    );

    sr2s_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    sr2s_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_job    (q_job),
        .o_pop    (pop),
        .i_alpha  (alpha),
        .i_radix  (radix),
        .o_sym_ch (o_sym_ch)
    );

endmodule
